[src/stb_pkg.sv]
// shared types and constants for the software timer bank
`timescale 1ns / 1ps
package stb_pkg;
    localparam int NUM_TIMERS = 8;
    localparam int TICK_WIDTH = 32;
    localparam int SLOT_W = 3;
    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);
    localparam int QDEPTH = 2;

    typedef enum logic [2:0] {
        CMD_START = 3'd0, CMD_STOP = 3'd1, CMD_FIRST_RUN = 3'd2, CMD_CHECK = 3'd3,
        CMD_REGISTER = 3'd4, CMD_DEREGISTER = 3'd5, CMD_SERVICE = 3'd6, CMD_BLOCK = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_ACK = 3'd0, KIND_FLAG = 3'd1, KIND_EXPIRY = 3'd2, KIND_DONE = 3'd3,
        KIND_BLOCK = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_STOP = 3'd0, ST_PRE_RUN = 3'd1, ST_RUN = 3'd2, ST_PRE_FOREVER = 3'd3,
        ST_FOREVER = 3'd4, ST_PRE_STOP = 3'd5
    } status_t;

    typedef struct packed {
        cmd_t                    command;
        logic [SLOT_W-1:0]       slot;
        logic                    slot_ok;
        logic [TICK_WIDTH-1:0]   timeout_ticks;
        logic                    has_callback;
        logic [TICK_WIDTH-1:0]   now_tick;
    } job_t;
endpackage

[src/stb_front.sv]
// command intake: classifies items and queues them for the executor
`timescale 1ns / 1ps
module stb_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [2:0]    command,
    input  logic [2:0]    slot,
    input  logic [31:0]   timeout_ticks,
    input  logic          has_callback,
    input  logic [31:0]   now_tick,
    output logic          job_valid,
    input  logic          job_ready,
    output stb_pkg::job_t job
);
    stb_pkg::job_t q_reg [stb_pkg::QDEPTH];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;
    stb_pkg::job_t in_job;
    logic          push, pop;

    always_comb
    begin
        in_job.command       = stb_pkg::cmd_t'(command);
        in_job.slot          = slot;
        in_job.slot_ok       = ({29'd0, slot} < 32'(stb_pkg::NUM_TIMERS));
        in_job.timeout_ticks = timeout_ticks[stb_pkg::TICK_WIDTH-1:0];
        in_job.has_callback  = has_callback;
        in_job.now_tick      = now_tick[stb_pkg::TICK_WIDTH-1:0];
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = job_valid && job_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= in_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

[src/stb_back.sv]
// executor: slot state, slot walk for service and block-time, result register
`timescale 1ns / 1ps
module stb_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_ready,
    input  stb_pkg::job_t job,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [2:0]    result_kind,
    output logic [2:0]    result_slot,
    output logic          flag,
    output logic [31:0]   block_time,
    output logic          last
);
    localparam int TW = stb_pkg::TICK_WIDTH;
    localparam int N  = stb_pkg::NUM_TIMERS;
    localparam int IW = stb_pkg::IDX_W;

    typedef enum logic [1:0] { S_IDLE, S_WALK, S_EMIT } state_t;

    state_t                state_reg;
    stb_pkg::status_t      status_reg [N];
    logic [TW-1:0]         start_reg  [N];
    logic [TW-1:0]         tmo_reg    [N];
    logic [N-1:0]          regd_reg, cb_reg;
    stb_pkg::job_t         job_reg;
    logic [IW-1:0]         idx_reg;
    logic [TW-1:0]         best_reg;
    logic                  ov_reg, last_reg, flag_reg;
    stb_pkg::kind_t        kind_reg;
    logic [2:0]            rslot_reg;
    logic [31:0]           bt_reg;

    logic [IW-1:0]         si;
    logic [TW-1:0]         el_one, el_walk, rem_walk;
    logic                  idx_end, out_free;
    stb_pkg::status_t      ws;

    assign si        = job.slot[IW-1:0];
    assign el_one    = job.now_tick - start_reg[si];
    assign ws        = status_reg[idx_reg];
    assign el_walk   = job_reg.now_tick - start_reg[idx_reg];
    assign rem_walk  = (el_walk <= tmo_reg[idx_reg]) ? tmo_reg[idx_reg] - el_walk : '0;
    assign idx_end   = ({{(32-IW){1'b0}}, idx_reg} == 32'(N - 1));
    assign out_free  = !ov_reg || out_ready;
    assign job_ready = (state_reg == S_IDLE) && out_free;

    assign out_valid   = ov_reg;
    assign result_kind = kind_reg;
    assign result_slot = rslot_reg;
    assign flag        = flag_reg;
    assign block_time  = bt_reg;
    assign last        = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            regd_reg  <= '0;
            cb_reg    <= '0;
            idx_reg   <= '0;
            for (int i = 0; i < N; i++)
            begin
                status_reg[i] <= stb_pkg::ST_STOP;
                start_reg[i]  <= '0;
                tmo_reg[i]    <= '0;
            end
        end
        else
        begin
            if (ov_reg && out_ready) ov_reg <= 1'b0;
            case (state_reg)
            S_IDLE:
            begin
                if (job_valid && out_free)
                begin
                    job_reg   <= job;
                    rslot_reg <= job.slot;
                    flag_reg  <= 1'b0;
                    bt_reg    <= '0;
                    last_reg  <= 1'b1;
                    kind_reg  <= stb_pkg::KIND_ACK;
                    ov_reg    <= 1'b1;
                    idx_reg   <= '0;
                    best_reg  <= '1;
                    case (job.command)
                    stb_pkg::CMD_START:
                        if (job.slot_ok)
                        begin
                            start_reg[si]  <= job.now_tick;
                            tmo_reg[si]    <= job.timeout_ticks;
                            status_reg[si] <= (&job.timeout_ticks) ?
                                stb_pkg::ST_PRE_FOREVER : stb_pkg::ST_PRE_RUN;
                        end
                    stb_pkg::CMD_STOP:
                        if (job.slot_ok) status_reg[si] <= stb_pkg::ST_STOP;
                    stb_pkg::CMD_FIRST_RUN:
                    begin
                        kind_reg <= stb_pkg::KIND_FLAG;
                        if (job.slot_ok && status_reg[si] == stb_pkg::ST_PRE_RUN)
                        begin
                            status_reg[si] <= stb_pkg::ST_RUN;
                            flag_reg       <= 1'b1;
                        end
                        else if (job.slot_ok && status_reg[si] == stb_pkg::ST_PRE_FOREVER)
                        begin
                            status_reg[si] <= stb_pkg::ST_FOREVER;
                            flag_reg       <= 1'b1;
                        end
                    end
                    stb_pkg::CMD_CHECK:
                    begin
                        kind_reg <= stb_pkg::KIND_FLAG;
                        if (job.slot_ok)
                        begin
                            case (status_reg[si])
                            stb_pkg::ST_PRE_RUN:  status_reg[si] <= stb_pkg::ST_RUN;
                            stb_pkg::ST_PRE_STOP: status_reg[si] <= stb_pkg::ST_STOP;
                            stb_pkg::ST_RUN:      flag_reg <= (el_one > tmo_reg[si]);
                            default: ;
                            endcase
                        end
                    end
                    stb_pkg::CMD_REGISTER:
                        if (job.slot_ok)
                        begin
                            regd_reg[si] <= 1'b1;
                            cb_reg[si]   <= job.has_callback;
                        end
                    stb_pkg::CMD_DEREGISTER:
                        if (job.slot_ok) regd_reg[si] <= 1'b0;
                    default:
                    begin
                        ov_reg    <= 1'b0;
                        state_reg <= S_WALK;
                    end
                    endcase
                end
            end
            S_WALK:
            begin
                if (out_free)
                begin
                    if (regd_reg[idx_reg])
                    begin
                        if (job_reg.command == stb_pkg::CMD_SERVICE)
                        begin
                            case (ws)
                            stb_pkg::ST_PRE_RUN:  status_reg[idx_reg] <= stb_pkg::ST_RUN;
                            stb_pkg::ST_PRE_STOP: status_reg[idx_reg] <= stb_pkg::ST_STOP;
                            stb_pkg::ST_RUN:
                                if (el_walk > tmo_reg[idx_reg] && cb_reg[idx_reg])
                                begin
                                    status_reg[idx_reg] <= stb_pkg::ST_PRE_STOP;
                                    ov_reg    <= 1'b1;
                                    kind_reg  <= stb_pkg::KIND_EXPIRY;
                                    rslot_reg <= 3'(idx_reg);
                                    flag_reg  <= 1'b1;
                                    bt_reg    <= '0;
                                    last_reg  <= 1'b0;
                                end
                            default: ;
                            endcase
                        end
                        else if (ws == stb_pkg::ST_PRE_STOP)
                        begin
                            best_reg <= '0;
                        end
                        else if (ws == stb_pkg::ST_RUN && rem_walk < best_reg)
                        begin
                            best_reg <= rem_walk;
                        end
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_end) state_reg <= S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ov_reg    <= 1'b1;
                    rslot_reg <= '0;
                    flag_reg  <= 1'b0;
                    last_reg  <= 1'b1;
                    if (job_reg.command == stb_pkg::CMD_SERVICE)
                    begin
                        kind_reg <= stb_pkg::KIND_DONE;
                        bt_reg   <= '0;
                    end
                    else
                    begin
                        kind_reg <= stb_pkg::KIND_BLOCK;
                        bt_reg   <= 32'(best_reg);
                    end
                    state_reg <= S_IDLE;
                end
            end
            default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

[src/soft_timer_bank.sv]
// top level of the software timer bank
// channels: s_axis takes commands, m_axis returns results, tlast on the final one
// single-slot commands (start, stop, first_run, check, register, deregister):
//   one result via queue entry and result register; a new command every cycle if no stall
// service pass and block-time query walk the eight slots one per cycle, pausing on a stall,
//   through the slot state registers, and take no new command until the final item is out
// service pass gives one expiry item per registered expired slot with callback, then pass done
// block-time query gives one item with the least remaining ticks
// a two-entry queue sits between command intake and the executor
// when the receiver stalls the result register holds and the walk pauses
// reset stops all slots, clears start, timeout, registered and callback flags
// no configuration registers
`timescale 1ns / 1ps
module soft_timer_bank (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // command, slot, timeout_ticks, has_callback, now_tick
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [2:0]  m_axis_tuser,  // result_kind
    output logic [39:0] m_axis_tdata,  // result_slot, flag, block_time
    output logic        m_axis_tlast
);
    logic          job_valid, job_ready;
    stb_pkg::job_t job;
    logic [2:0]    result_slot;
    logic          flag;
    logic [31:0]   block_time;

    stb_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .command(s_axis_tdata[2:0]), .slot(s_axis_tdata[5:3]),
        .timeout_ticks(s_axis_tdata[37:6]), .has_callback(s_axis_tdata[38]),
        .now_tick(s_axis_tdata[70:39]),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    stb_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .result_kind(m_axis_tuser), .result_slot(result_slot), .flag(flag),
        .block_time(block_time), .last(m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, block_time, flag, result_slot};
endmodule

[tb/soft_timer_bank_tb.sv]
// self-checking testbench for the software timer bank: directed and random commands
`timescale 1ns / 1ps
module soft_timer_bank_tb;

    typedef struct packed {
        stb_pkg::kind_t kind;
        logic [2:0]     slot;
        logic           flag;
        logic [31:0]    btime;
        logic           last;
    } timer_result_t;

    class timer_scoreboard;
        stb_pkg::status_t status [8];
        logic [31:0]      origin_tick [8];
        logic [31:0]      tmo [8];
        bit               registered [8];
        bit               callback [8];
        timer_result_t    pending [$];
        int               errors;
        int               checked;

        function new();
            for (int i = 0; i < 8; i++)
            begin
                status[i] = stb_pkg::ST_STOP;
                origin_tick[i] = '0;
                tmo[i] = '0;
                registered[i] = 0;
                callback[i] = 0;
            end
            errors = 0;
            checked = 0;
        endfunction

        function void push(stb_pkg::kind_t k, int s, bit f, logic [31:0] b, bit l);
            timer_result_t r;
            r.kind = k;
            r.slot = s[2:0];
            r.flag = f;
            r.btime = b;
            r.last = l;
            pending.push_back(r);
        endfunction

        function bit timeout_hit(int s, logic [31:0] now);
            logic [31:0] el;
            el = now - origin_tick[s];
            case (status[s])
                stb_pkg::ST_PRE_RUN: status[s] = stb_pkg::ST_RUN;
                stb_pkg::ST_PRE_STOP: status[s] = stb_pkg::ST_STOP;
                stb_pkg::ST_RUN: return el > tmo[s];
                default: ;
            endcase
            return 0;
        endfunction

        function void note_command(stb_pkg::cmd_t c, int s, logic [31:0] t, bit cb,
                                   logic [31:0] now);
            bit f;
            logic [31:0] best;
            logic [31:0] el;
            logic [31:0] rem;
            f = 0;
            case (c)
                stb_pkg::CMD_START:
                begin
                    origin_tick[s] = now;
                    tmo[s] = t;
                    status[s] = (t == '1) ? stb_pkg::ST_PRE_FOREVER : stb_pkg::ST_PRE_RUN;
                    push(stb_pkg::KIND_ACK, s, 0, 0, 1);
                end
                stb_pkg::CMD_STOP:
                begin
                    status[s] = stb_pkg::ST_STOP;
                    push(stb_pkg::KIND_ACK, s, 0, 0, 1);
                end
                stb_pkg::CMD_FIRST_RUN:
                begin
                    if (status[s] == stb_pkg::ST_PRE_RUN)
                    begin
                        status[s] = stb_pkg::ST_RUN;
                        f = 1;
                    end
                    else if (status[s] == stb_pkg::ST_PRE_FOREVER)
                    begin
                        status[s] = stb_pkg::ST_FOREVER;
                        f = 1;
                    end
                    push(stb_pkg::KIND_FLAG, s, f, 0, 1);
                end
                stb_pkg::CMD_CHECK:
                begin
                    f = timeout_hit(s, now);
                    push(stb_pkg::KIND_FLAG, s, f, 0, 1);
                end
                stb_pkg::CMD_REGISTER:
                begin
                    registered[s] = 1;
                    callback[s] = cb;
                    push(stb_pkg::KIND_ACK, s, 0, 0, 1);
                end
                stb_pkg::CMD_DEREGISTER:
                begin
                    registered[s] = 0;
                    push(stb_pkg::KIND_ACK, s, 0, 0, 1);
                end
                stb_pkg::CMD_SERVICE:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        if (registered[i] && timeout_hit(i, now) && callback[i])
                        begin
                            status[i] = stb_pkg::ST_PRE_STOP;
                            push(stb_pkg::KIND_EXPIRY, i, 1, 0, 0);
                        end
                    end
                    push(stb_pkg::KIND_DONE, 0, 0, 0, 1);
                end
                default:
                begin
                    best = '1;
                    for (int i = 0; i < 8; i++)
                    begin
                        if (!registered[i])
                            continue;
                        if (status[i] == stb_pkg::ST_PRE_STOP)
                            best = 0;
                        else if (status[i] == stb_pkg::ST_RUN)
                        begin
                            el = now - origin_tick[i];
                            rem = (el <= tmo[i]) ? tmo[i] - el : 0;
                            if (rem < best)
                                best = rem;
                        end
                    end
                    push(stb_pkg::KIND_BLOCK, 0, 0, best, 1);
                end
            endcase
        endfunction

        function void check_result(timer_result_t got);
            timer_result_t exp;
            checked++;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result kind=%0d slot=%0d", $time, got.kind, got.slot);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp)
            begin
                errors++;
                $display("%0t: mismatch expected kind=%0d slot=%0d flag=%0d bt=%h last=%0d",
                         $time, exp.kind, exp.slot, exp.flag, exp.btime, exp.last);
                $display("%0t:          actual   kind=%0d slot=%0d flag=%0d bt=%h last=%0d",
                         $time, got.kind, got.slot, got.flag, got.btime, got.last);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [2:0]  m_axis_tuser;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    timer_scoreboard sb;
    logic [31:0] tick;
    int          cycles;
    bit          quiet;
    bit          hold_long;
    int          sent;

    soft_timer_bank u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 200000)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("** soft_timer_bank: FAILED **");
                $finish;
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int gap;
        m_axis_tready <= 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_long)
            begin
                m_axis_tready <= 0;
                repeat (150) @(posedge clk);
                hold_long = 0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 14);
                m_axis_tready <= 0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        timer_result_t r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            r.kind = stb_pkg::kind_t'(m_axis_tuser);
            r.slot = m_axis_tdata[2:0];
            r.flag = m_axis_tdata[3];
            r.btime = m_axis_tdata[35:4];
            r.last = m_axis_tlast;
            sb.check_result(r);
        end
    end

    task automatic send(stb_pkg::cmd_t c, int s, logic [31:0] t, bit cb, logic [31:0] now);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 14);
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {1'b0, now, cb, t, s[2:0], c};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_command(c, s, t, cb, now);
        sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic random_cmd();
        stb_pkg::cmd_t c;
        logic [31:0]   t;
        int            r;
        r = $urandom_range(0, 9);
        c = stb_pkg::cmd_t'($urandom_range(0, 7));
        if (r < 3)
            t = $urandom_range(0, 60);
        else if (r < 5)
            t = '1;
        else
            t = $urandom;
        tick = tick + $urandom_range(0, 40);
        if (r == 9)
            tick = $urandom;
        send(c, $urandom_range(0, 7), t, $urandom_range(0, 1), tick);
    endtask

    initial
    begin
        sb = new();
        rst_n = 0;
        quiet = 0;
        hold_long = 0;
        sent = 0;
        tick = 32'hffff_ffe0;
        s_axis_tvalid <= 0;
        s_axis_tdata <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: every command, wrap of the tick, forever, expiry with and without callback
        send(stb_pkg::CMD_BLOCK, 0, 0, 0, tick);
        send(stb_pkg::CMD_REGISTER, 0, 0, 1, tick);
        send(stb_pkg::CMD_REGISTER, 1, 0, 0, tick);
        send(stb_pkg::CMD_REGISTER, 2, 0, 1, tick);
        send(stb_pkg::CMD_REGISTER, 2, 0, 1, tick);
        send(stb_pkg::CMD_START, 0, 32'd10, 0, tick);
        send(stb_pkg::CMD_START, 1, 32'd0, 0, tick);
        send(stb_pkg::CMD_START, 2, 32'hffff_ffff, 0, tick);
        send(stb_pkg::CMD_FIRST_RUN, 0, 0, 0, tick);
        send(stb_pkg::CMD_FIRST_RUN, 0, 0, 0, tick);
        send(stb_pkg::CMD_FIRST_RUN, 2, 0, 0, tick);
        send(stb_pkg::CMD_CHECK, 1, 0, 0, tick);
        send(stb_pkg::CMD_BLOCK, 0, 0, 0, tick + 3);
        send(stb_pkg::CMD_CHECK, 0, 0, 0, 32'd20);
        send(stb_pkg::CMD_SERVICE, 0, 0, 0, 32'd40);
        send(stb_pkg::CMD_BLOCK, 0, 0, 0, 32'd40);
        send(stb_pkg::CMD_SERVICE, 0, 0, 0, 32'd41);
        send(stb_pkg::CMD_DEREGISTER, 1, 0, 0, 0);
        send(stb_pkg::CMD_STOP, 2, 0, 0, 0);
        send(stb_pkg::CMD_START, 7, 32'h7fff_ffff, 0, 32'hffff_ffff);
        send(stb_pkg::CMD_CHECK, 7, 0, 0, 32'h5555_aaaa);
        send(stb_pkg::CMD_START, 5, 32'hffff_fffe, 1, 32'haaaa_5555);
        drain();

        // long result stall while commands keep coming
        hold_long = 1;
        for (int i = 0; i < 12; i++)
            random_cmd();
        drain();

        // mostly well-formed timer lifecycles with random content
        for (int i = 0; i < 70; i++)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                int s;
                s = $urandom_range(0, 7);
                tick = tick + $urandom_range(0, 20);
                send(stb_pkg::CMD_REGISTER, s, 0, $urandom_range(0, 1), tick);
                send(stb_pkg::CMD_START, s, $urandom_range(0, 30), 0, tick);
                tick = tick + $urandom_range(0, 40);
                send(stb_pkg::CMD_SERVICE, 0, 0, 0, tick);
                i += 2;
            end
            else
                random_cmd();
        end
        quiet = 1;
        for (int i = 0; i < 25; i++)
            random_cmd();
        drain();

        $display("run covered %0d commands and %0d results, all command types,", sent,
                 sb.checked);
        $display("tick wraparound, forever timers, expiries and long stalls");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("** soft_timer_bank: PASSED **");
        else
            $display("** soft_timer_bank: FAILED **");
        $finish;
    end
endmodule

[sim.f]
src/stb_pkg.sv
src/stb_front.sv
src/stb_back.sv
src/soft_timer_bank.sv
tb/soft_timer_bank_tb.sv
